// File: rtl/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// Shared widths, request codes and controller/datapath signal groups for the
// circular byte FIFO.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int DEPTH_DEF = 4096;
  localparam int REQ_W     = 2;
  localparam int DATA_W    = 8;
  localparam int LEN_W     = 13;
  localparam int CNT_W     = 13;
  localparam int SIZE_W    = 13;

  localparam logic [REQ_W-1:0] REQ_PUSH  = REQ_W'(0);
  localparam logic [REQ_W-1:0] REQ_POP   = REQ_W'(1);
  localparam logic [REQ_W-1:0] REQ_QUERY = REQ_W'(2);

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } brb_cmd_t;

  typedef struct packed {
    logic slot_free;
  } brb_sts_t;

endpackage

// File: rtl/brb_in_if.sv
// ----------------------------------------------------------------------------
// brb_in_if
// Request channel: one beat carries one push, pop or query item.
// ----------------------------------------------------------------------------
interface brb_in_if;
  logic                        valid;
  logic                        ready;
  logic [brb_pkg::REQ_W-1:0]   req_type;
  logic [brb_pkg::DATA_W-1:0]  data_byte;
  logic [brb_pkg::LEN_W-1:0]   block_length;
  logic                        first_in_block;

  modport source (
    output valid, req_type, data_byte, block_length, first_in_block,
    input  ready
  );

  modport sink (
    input  valid, req_type, data_byte, block_length, first_in_block,
    output ready
  );
endinterface

// File: rtl/brb_out_if.sv
// ----------------------------------------------------------------------------
// brb_out_if
// Result channel: one beat per request item.
// ----------------------------------------------------------------------------
interface brb_out_if;
  logic                        valid;
  logic                        ready;
  logic                        accepted;
  logic [brb_pkg::DATA_W-1:0]  read_byte;
  logic [brb_pkg::CNT_W-1:0]   used_count;
  logic [brb_pkg::CNT_W-1:0]   free_count;

  modport source (
    output valid, accepted, read_byte, used_count, free_count,
    input  ready
  );

  modport sink (
    input  valid, accepted, read_byte, used_count, free_count,
    output ready
  );
endinterface

// File: rtl/brb_ram.sv
// ----------------------------------------------------------------------------
// brb_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// File: rtl/brb_ctrl.sv
// ----------------------------------------------------------------------------
// brb_ctrl
// Sequencer: take an item, execute it, hand the result to the output stage.
// ----------------------------------------------------------------------------
module brb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  brb_pkg::brb_sts_t sts,
  output brb_pkg::brb_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready    = (state_r == ST_IDLE);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.exec    = (state_r == ST_EXEC);
  assign cmd.load    = (state_r == ST_EMIT) && sts.slot_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/brb_dp.sv
// ----------------------------------------------------------------------------
// brb_dp
// Datapath: ring pointers, block admission, byte store and output register.
// ----------------------------------------------------------------------------
module brb_dp #(
  parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  brb_pkg::brb_cmd_t             cmd,
  output brb_pkg::brb_sts_t             sts,
  input  logic                          cfg_wr_en,
  input  logic [brb_pkg::SIZE_W-1:0]    cfg_wr_data,
  input  logic [brb_pkg::REQ_W-1:0]     in_req_type,
  input  logic [brb_pkg::DATA_W-1:0]    in_data_byte,
  input  logic [brb_pkg::LEN_W-1:0]     in_block_length,
  input  logic                          in_first_in_block,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_accepted,
  output logic [brb_pkg::DATA_W-1:0]    out_read_byte,
  output logic [brb_pkg::CNT_W-1:0]     out_used_count,
  output logic [brb_pkg::CNT_W-1:0]     out_free_count
);

  localparam int PW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int LW   = brb_pkg::LEN_W;
  localparam int SW   = brb_pkg::SIZE_W;
  localparam int CMPW = (LW > CW) ? ((LW > SW) ? LW : SW) : ((CW > SW) ? CW : SW);

  // item
  logic [brb_pkg::REQ_W-1:0]  req_r;
  logic [brb_pkg::DATA_W-1:0] data_r;
  logic [LW-1:0]              len_r;
  logic                       first_r;

  // ring and block state
  logic [CW-1:0] size_r;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [PW-1:0] wp_r, wp_nxt;
  logic          adm_r, adm_nxt;
  logic          kind_pop_r, kind_pop_nxt;
  logic [LW-1:0] left_r, left_nxt;

  // result of the executed item
  logic acc_r, acc_nxt;
  logic pop_act_r, pop_act_nxt;

  // output stage
  logic                       out_valid_r;
  logic                       out_acc_r;
  logic [brb_pkg::DATA_W-1:0] out_rd_r;
  logic [brb_pkg::CNT_W-1:0]  out_used_r;
  logic [brb_pkg::CNT_W-1:0]  out_free_r;

  logic [CW-1:0]   rp_e, wp_e, used_cnt, free_cnt;
  logic [CW-1:0]   rp_inc, wp_inc;
  logic [CMPW-1:0] cfg_ext, size_clamped;
  logic            ram_we, ram_re;
  logic [brb_pkg::DATA_W-1:0] ram_rdata;

  assign rp_e = CW'(rp_r);
  assign wp_e = CW'(wp_r);
  assign used_cnt = (rp_e <= wp_e) ? (wp_e - rp_e) : (size_r + wp_e - rp_e);
  assign free_cnt = (rp_e <= wp_e) ? (size_r + rp_e - wp_e) : (rp_e - wp_e);
  assign rp_inc = rp_e + CW'(1);
  assign wp_inc = wp_e + CW'(1);

  assign cfg_ext = CMPW'(cfg_wr_data);
  always_comb begin
    size_clamped = cfg_ext;
    if (cfg_ext == '0) begin
      size_clamped = CMPW'(1);
    end else if (cfg_ext > CMPW'(DEPTH)) begin
      size_clamped = CMPW'(DEPTH);
    end
  end

  always_comb begin
    logic          is_push;
    logic          is_pop;
    logic          act;
    logic [CW-1:0] room;
    logic [LW-1:0] left_base;
    is_push      = (req_r == brb_pkg::REQ_PUSH);
    is_pop       = (req_r == brb_pkg::REQ_POP);
    act          = 1'b0;
    room         = is_push ? free_cnt : used_cnt;
    left_base    = left_r;
    adm_nxt      = adm_r;
    kind_pop_nxt = kind_pop_r;
    rp_nxt       = rp_r;
    wp_nxt       = wp_r;
    if (is_push || is_pop) begin
      if (first_r) begin
        adm_nxt   = 1'b0;
        left_base = '0;
        if ((len_r != '0) && (CMPW'(len_r) < CMPW'(room))) begin
          adm_nxt      = 1'b1;
          kind_pop_nxt = is_pop;
          left_base    = len_r;
          act          = 1'b1;
        end
      end else if (adm_r && (kind_pop_r == is_pop) && (left_r != '0)) begin
        act = 1'b1;
      end
    end
    left_nxt = left_base;
    if (act) begin
      left_nxt = left_base - LW'(1);
      if (left_nxt == '0) begin
        adm_nxt = 1'b0;
      end
      if (is_push) begin
        wp_nxt = (wp_inc >= size_r) ? '0 : PW'(wp_inc);
      end else begin
        rp_nxt = (rp_inc >= size_r) ? '0 : PW'(rp_inc);
      end
    end
    acc_nxt     = act || (req_r == brb_pkg::REQ_QUERY);
    pop_act_nxt = act && is_pop;
    ram_we      = cmd.exec && act && is_push;
    ram_re      = cmd.exec && act && is_pop;
  end

  brb_ram #(
    .WIDTH (brb_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (wp_r),
    .wdata   (data_r),
    .re      (ram_re),
    .raddr   (rp_r),
    .rdata_r (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r   <= in_req_type;
      data_r  <= in_data_byte;
      len_r   <= in_block_length;
      first_r <= in_first_in_block;
    end
    if (cmd.exec) begin
      acc_r     <= acc_nxt;
      pop_act_r <= pop_act_nxt;
    end
    if (cmd.load) begin
      out_acc_r  <= acc_r;
      out_rd_r   <= pop_act_r ? ram_rdata : '0;
      out_used_r <= brb_pkg::CNT_W'(used_cnt);
      out_free_r <= brb_pkg::CNT_W'(free_cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= CW'(DEPTH);
      rp_r        <= '0;
      wp_r        <= '0;
      adm_r       <= 1'b0;
      kind_pop_r  <= 1'b0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        size_r     <= CW'(size_clamped);
        rp_r       <= '0;
        wp_r       <= '0;
        adm_r      <= 1'b0;
        kind_pop_r <= 1'b0;
        left_r     <= '0;
      end else if (cmd.exec) begin
        rp_r       <= rp_nxt;
        wp_r       <= wp_nxt;
        adm_r      <= adm_nxt;
        kind_pop_r <= kind_pop_nxt;
        left_r     <= left_nxt;
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.slot_free  = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_accepted   = out_acc_r;
  assign out_read_byte  = out_rd_r;
  assign out_used_count = out_used_r;
  assign out_free_count = out_free_r;

endmodule

// File: rtl/byte_ring_buffer_block_fifo_core.sv
// Each item is taken, executed with the store access and then loaded into
// the output register; the next request is not taken until that load.
// A waiting result does not block the next request; a stalled output holds it.
// Reset (sync, active low): pointers and block state cleared, size = DEPTH;
// store contents undefined until written.
// ----------------------------------------------------------------------------
// byte_ring_buffer_block_fifo_core
// Circular byte FIFO with all-or-nothing block push/pop and count queries.
// ----------------------------------------------------------------------------
module byte_ring_buffer_block_fifo_core #(
  parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [brb_pkg::SIZE_W-1:0] cfg_wr_data,
  brb_in_if.sink                     in_ch,
  brb_out_if.source                  out_ch
);

  brb_pkg::brb_cmd_t cmd;
  brb_pkg::brb_sts_t sts;

  brb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  brb_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_req_type       (in_ch.req_type),
    .in_data_byte      (in_ch.data_byte),
    .in_block_length   (in_ch.block_length),
    .in_first_in_block (in_ch.first_in_block),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_accepted      (out_ch.accepted),
    .out_read_byte     (out_ch.read_byte),
    .out_used_count    (out_ch.used_count),
    .out_free_count    (out_ch.free_count)
  );

`ifndef SYNTH
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request taken while an item is in flight");

  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(cmd.load))
    else $error("result beat without a load");

  a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.accepted) |-> (out_ch.read_byte == '0))
    else $error("nonzero read byte on a rejected item");
`endif

endmodule
